// ----- rtl/core/trqs_pkg.sv -----
package trqs_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] slot_st_t;

    localparam op_t OP_ENQ  = 2'd0;
    localparam op_t OP_TENQ = 2'd1;
    localparam op_t OP_DEQ  = 2'd2;
    localparam op_t OP_PROC = 2'd3;

    localparam slot_st_t ST_FREE  = 2'd0;
    localparam slot_st_t ST_TIMER = 2'd1;
    localparam slot_st_t ST_RUN   = 2'd2;

endpackage

// ----- rtl/core/timer_and_run_queue_scheduler.sv -----
// Timer list and FIFO run queue over MAX_TASKS task slots.
//
// Command channel: present op, task_id, is_fast, delay_ms and now, raise
// start; the item is taken at a clock edge where start is high and busy is
// low. busy then stays high until the item is fully handled.
// Result channel: each dispatch shows dispatched_task, timed_out and last
// for one cycle with valid high. The receiver cannot stall; a process tick
// sends its dispatches in consecutive cycles, last marking the final one.
// A decode state comes first, then a sequencer walks the lists one entry
// per cycle through one shared deadline comparator.
// Enqueue: a fast dispatch shows in the cycle in which busy drops; an
// armed timer for the task is first pulled from the timer list.
// Timed enqueue: removal of an armed entry, sorted search, shift-open.
// Dequeue: removal from the task's list. Process tick: each expired entry
// moves to the run queue, then one cycle per dispatch.
// Reset clears slot states, timeout marks and both list counts; list
// contents and deadlines need no clearing since counts and slot states
// guard every read.
module timer_and_run_queue_scheduler
    import trqs_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  task_id,
    input  logic        is_fast,
    input  logic [31:0] delay_ms,
    input  logic [31:0] now,
    output logic        valid,
    output logic [3:0]  dispatched_task,
    output logic        timed_out,
    output logic        last
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RM   = 3'd2;
    localparam logic [2:0] S_ENQ  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_SHF  = 3'd5;
    localparam logic [2:0] S_EXP  = 3'd6;
    localparam logic [2:0] S_DSP  = 3'd7;

    // slot state and lists
    slot_st_t       status_reg   [MAX_TASKS];
    logic           mark_reg     [MAX_TASKS];
    logic [31:0]    deadline_reg [MAX_TASKS];
    logic [SW-1:0]  tlist_reg    [MAX_TASKS];
    logic [SW-1:0]  rlist_reg    [MAX_TASKS];

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  tcnt_reg, tcnt_next;
    logic [CW-1:0]  rcnt_reg, rcnt_next;
    logic           found_reg, found_next;
    logic           rm_run_reg, rm_run_next;
    op_t            op_reg;
    logic [SW-1:0]  id_reg, id_next;
    logic           id_ok_reg;
    logic           fast_reg;
    logic [31:0]    dl_reg;
    logic [31:0]    now_reg;
    logic           valid_reg, valid_next;
    logic [3:0]     task_reg, task_next;
    logic           tmo_reg, tmo_next;
    logic           last_reg, last_next;

    logic           accept;
    logic [32:0]    dl_sum;
    logic [CW-1:0]  i_inc, i_dec;
    logic [SW-1:0]  i_idx;
    logic [SW-1:0]  rm_elem;
    logic [CW-1:0]  rm_cnt;
    logic           rm_hit;
    logic           rm_end;
    slot_st_t       id_st;
    logic [SW-1:0]  tl_head;
    logic [SW-1:0]  rl_cur;
    logic [SW-1:0]  cmp_idx;
    logic [31:0]    cmp_lim;
    logic           cmp_le;
    logic           exp_hit;
    logic           ins_adv;

    function automatic logic rm_end_dsp(input logic [CW-1:0] a, input logic [CW-1:0] n);
        rm_end_dsp = ((a + CW'(1)) == n);
    endfunction

    assign accept  = start && (state_reg == S_IDLE);
    assign dl_sum  = {1'b0, now} + {1'b0, delay_ms};
    assign i_inc   = i_reg + CW'(1);
    assign i_dec   = i_reg - CW'(1);
    assign i_idx   = i_reg[SW-1:0];
    assign rm_elem = rm_run_reg ? rlist_reg[i_idx] : tlist_reg[i_idx];
    assign rm_cnt  = rm_run_reg ? rcnt_reg : tcnt_reg;
    assign rm_hit  = found_reg || (rm_elem == id_reg);
    assign rm_end  = (i_inc == rm_cnt);
    assign id_st   = status_reg[id_reg];
    assign tl_head = tlist_reg[0];
    assign rl_cur  = rlist_reg[i_idx];

    // shared deadline comparator: expiry against now, insertion against new deadline
    assign cmp_idx = (state_reg == S_EXP) ? tl_head : tlist_reg[i_idx];
    assign cmp_lim = (state_reg == S_EXP) ? now_reg : dl_reg;
    assign cmp_le  = deadline_reg[cmp_idx] <= cmp_lim;
    assign exp_hit = (tcnt_reg != '0) && cmp_le;
    assign ins_adv = (i_reg < tcnt_reg) && cmp_le;

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        pos_next    = pos_reg;
        tcnt_next   = tcnt_reg;
        rcnt_next   = rcnt_reg;
        found_next  = found_reg;
        rm_run_next = rm_run_reg;
        id_next     = id_reg;
        valid_next  = 1'b0;
        task_next   = task_reg;
        tmo_next    = tmo_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DEC;
                    id_next    = SW'(task_id);
                end
            end
            S_DEC:
            begin
                i_next     = '0;
                found_next = 1'b0;
                if (op_reg == OP_PROC)
                begin
                    state_next = S_EXP;
                end
                else if (!id_ok_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (op_reg == OP_DEQ)
                begin
                    rm_run_next = (id_st == ST_RUN);
                    state_next  = (id_st == ST_FREE) ? S_IDLE : S_RM;
                end
                else if (id_st == ST_RUN)
                begin
                    state_next = S_IDLE;
                end
                else if (id_st == ST_TIMER)
                begin
                    rm_run_next = 1'b0;
                    state_next  = S_RM;
                end
                else
                begin
                    state_next = S_ENQ;
                end
            end
            S_RM:
            begin
                // walk to the entry, then close the gap one entry a cycle
                if (rm_end)
                begin
                    if (rm_run_reg)
                        rcnt_next = rcnt_reg - CW'(1);
                    else
                        tcnt_next = tcnt_reg - CW'(1);
                    case (op_reg)
                        OP_DEQ:  state_next = S_IDLE;
                        OP_PROC: state_next = S_EXP;
                        default: state_next = S_ENQ;
                    endcase
                end
                else
                begin
                    i_next     = i_inc;
                    found_next = rm_hit;
                end
            end
            S_ENQ:
            begin
                i_next = '0;
                if (op_reg == OP_TENQ)
                begin
                    state_next = S_INS;
                end
                else if (fast_reg)
                begin
                    valid_next = 1'b1;
                    task_next  = 4'(id_reg);
                    tmo_next   = mark_reg[id_reg];
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rcnt_next  = rcnt_reg + CW'(1);
                    state_next = S_IDLE;
                end
            end
            S_INS:
            begin
                if (ins_adv)
                begin
                    i_next = i_inc;
                end
                else
                begin
                    pos_next   = i_reg;
                    i_next     = tcnt_reg;
                    state_next = S_SHF;
                end
            end
            S_SHF:
            begin
                if (i_reg == pos_reg)
                begin
                    tcnt_next  = tcnt_reg + CW'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next = i_dec;
                end
            end
            S_EXP:
            begin
                i_next     = '0;
                found_next = 1'b0;
                if (exp_hit)
                begin
                    id_next     = tl_head;
                    rm_run_next = 1'b0;
                    rcnt_next   = rcnt_reg + CW'(1);
                    state_next  = S_RM;
                end
                else if (rcnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DSP;
                end
            end
            S_DSP:
            begin
                valid_next = 1'b1;
                task_next  = 4'(rl_cur);
                tmo_next   = mark_reg[rl_cur];
                last_next  = rm_end_dsp(i_reg, rcnt_reg);
                if (last_next)
                begin
                    rcnt_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next = i_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tcnt_reg   <= '0;
            rcnt_reg   <= '0;
            valid_reg  <= 1'b0;
            i_reg      <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            rm_run_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tcnt_reg   <= tcnt_next;
            rcnt_reg   <= rcnt_next;
            valid_reg  <= valid_next;
            i_reg      <= i_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            rm_run_reg <= rm_run_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        task_reg <= task_next;
        tmo_reg  <= tmo_next;
        last_reg <= last_next;
        if (accept)
        begin
            op_reg    <= op;
            fast_reg  <= is_fast;
            now_reg   <= now;
            id_ok_reg <= {28'd0, task_id} < 32'(MAX_TASKS);
            dl_reg    <= dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
        end
    end

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                status_reg[k] <= ST_FREE;
                mark_reg[k]   <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_DEC:
                begin
                    if (op_reg != OP_PROC && id_ok_reg &&
                        (op_reg == OP_DEQ || id_st == ST_TIMER))
                        status_reg[id_reg] <= ST_FREE;
                end
                S_ENQ:
                begin
                    if (op_reg == OP_TENQ)
                        mark_reg[id_reg] <= 1'b0;
                    else if (!fast_reg)
                        status_reg[id_reg] <= ST_RUN;
                end
                S_SHF:
                begin
                    if (i_reg == pos_reg)
                        status_reg[id_reg] <= ST_TIMER;
                end
                S_EXP:
                begin
                    if (exp_hit)
                    begin
                        status_reg[tl_head] <= ST_RUN;
                        mark_reg[tl_head]   <= 1'b1;
                    end
                end
                S_DSP:
                begin
                    status_reg[rl_cur] <= ST_FREE;
                end
                default:
                begin
                end
            endcase
        end
    end

    // list contents and deadlines
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RM:
            begin
                if (rm_hit && !rm_end)
                begin
                    if (rm_run_reg)
                        rlist_reg[i_idx] <= rlist_reg[i_inc[SW-1:0]];
                    else
                        tlist_reg[i_idx] <= tlist_reg[i_inc[SW-1:0]];
                end
            end
            S_ENQ:
            begin
                if (op_reg == OP_TENQ)
                    deadline_reg[id_reg] <= dl_reg;
                else if (!fast_reg)
                    rlist_reg[rcnt_reg[SW-1:0]] <= id_reg;
            end
            S_SHF:
            begin
                if (i_reg == pos_reg)
                    tlist_reg[i_idx] <= id_reg;
                else
                    tlist_reg[i_idx] <= tlist_reg[i_dec[SW-1:0]];
            end
            S_EXP:
            begin
                if (exp_hit)
                    rlist_reg[rcnt_reg[SW-1:0]] <= tl_head;
            end
            default:
            begin
            end
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign valid           = valid_reg;
    assign dispatched_task = task_reg;
    assign timed_out       = tmo_reg;
    assign last            = last_reg;

endmodule

// ----- rtl/core/trqs_chk.sv -----
module trqs_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic valid,
    input logic last
);

    // an accepted item keeps the block busy for at least the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // dispatches of one item come back to back until the last one
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |=> valid)
        else $error("gap inside a dispatch burst");

    // the final dispatch closes the burst
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !valid)
        else $error("dispatch directly after last");

    // every result comes from work in progress
    a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result without an item in progress");

endmodule

bind timer_and_run_queue_scheduler trqs_chk u_trqs_chk (.*);

// ----- tb/trqs_checker.sv -----
`timescale 1ns / 1ps

module trqs_checker
    import trqs_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  task_id,
    input  logic        is_fast,
    input  logic [31:0] delay_ms,
    input  logic [31:0] now,
    input  logic        valid,
    input  logic [3:0]  dispatched_task,
    input  logic        timed_out,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          dispatch_seen
);

    typedef struct packed {
        logic [3:0] slot;
        logic       mark;
        logic       fin;
    } dispatch_t;

    slot_st_t    sched_state [MAX_TASKS];
    logic [31:0] sched_dl    [MAX_TASKS];
    logic        sched_mark  [MAX_TASKS];
    logic [3:0]  timer_q[$];
    logic [3:0]  run_q[$];
    dispatch_t   dispatch_q[$];

    function automatic void pull_slot(ref logic [3:0] q[$], input logic [3:0] id);
        foreach (q[i])
        begin
            if (q[i] == id)
            begin
                q.delete(i);
                return;
            end
        end
    endfunction

    // Advance the scheduler mirror by one command and queue its dispatches.
    task automatic predict_dispatches(input op_t c, input logic [3:0] id, input logic f,
                                      input logic [31:0] dly, input logic [31:0] t_now);
        logic [32:0] sum;
        logic [31:0] dl;
        int          pos;
        logic [3:0]  s;
        if (c == OP_PROC)
        begin
            while (timer_q.size() > 0 && sched_dl[timer_q[0]] <= t_now)
            begin
                s = timer_q.pop_front();
                sched_mark[s] = 1'b1;
                if (run_q.size() < MAX_TASKS)
                    run_q.push_back(s);
                sched_state[s] = ST_RUN;
            end
            foreach (run_q[i])
            begin
                sched_state[run_q[i]] = ST_FREE;
                dispatch_q.push_back('{run_q[i], sched_mark[run_q[i]],
                                       i == run_q.size() - 1});
            end
            run_q.delete();
            return;
        end
        if (id >= MAX_TASKS)
            return;
        if (c == OP_DEQ)
        begin
            if (sched_state[id] == ST_RUN)
                pull_slot(run_q, id);
            else if (sched_state[id] == ST_TIMER)
                pull_slot(timer_q, id);
            sched_state[id] = ST_FREE;
            return;
        end
        if (sched_state[id] == ST_RUN)
            return;
        if (sched_state[id] == ST_TIMER)
        begin
            pull_slot(timer_q, id);
            sched_state[id] = ST_FREE;
        end
        if (c == OP_ENQ)
        begin
            if (f)
                dispatch_q.push_back('{id, sched_mark[id], 1'b1});
            else
            begin
                if (run_q.size() < MAX_TASKS)
                    run_q.push_back(id);
                sched_state[id] = ST_RUN;
            end
            return;
        end
        sum = {1'b0, t_now} + {1'b0, dly};
        dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        sched_dl[id] = dl;
        sched_mark[id] = 1'b0;
        pos = 0;
        while (pos < timer_q.size() && sched_dl[timer_q[pos]] <= dl)
            pos++;
        if (timer_q.size() < MAX_TASKS)
            timer_q.insert(pos, id);
        sched_state[id] = ST_TIMER;
    endtask

    initial
    begin
        fail_count = 0;
        dispatch_seen = 0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            sched_state[i] = ST_FREE;
            sched_mark[i] = 1'b0;
            sched_dl[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        dispatch_t exp_d;
        if (rst_n)
        begin
            // Check the result first: a command taken this edge cannot
            // have produced a dispatch yet.
            if (valid)
            begin
                dispatch_seen++;
                if (dispatch_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected dispatch task=%0d timed_out=%0b last=%0b",
                             $time, dispatched_task, timed_out, last);
                end
                else
                begin
                    exp_d = dispatch_q.pop_front();
                    if (exp_d.slot !== dispatched_task || exp_d.mark !== timed_out ||
                        exp_d.fin !== last)
                    begin
                        fail_count++;
                        $display("%0t: dispatch mismatch expected task=%0d to=%0b last=%0b, got task=%0d to=%0b last=%0b",
                                 $time, exp_d.slot, exp_d.mark, exp_d.fin,
                                 dispatched_task, timed_out, last);
                    end
                end
            end
            if (start && !busy)
                predict_dispatches(op, task_id, is_fast, delay_ms, now);
        end
        pending = dispatch_q.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
    import trqs_pkg::*;
();

    localparam int MAX_TASKS   = 16;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [3:0]  task_id;
    logic        is_fast;
    logic [31:0] delay_ms;
    logic [31:0] now;
    logic        valid;
    logic [3:0]  dispatched_task;
    logic        timed_out;
    logic        last;
    int          fail_count;
    int          pending;
    int          dispatch_seen;
    int          cycle_count;
    int          items_sent;
    logic [31:0] clock_ms;   // running time base for well-formed traffic

    timer_and_run_queue_scheduler #(.MAX_TASKS(MAX_TASKS)) dut (.*);

    trqs_checker #(.MAX_TASKS(MAX_TASKS)) checker_i (.*);

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: bail out if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one command at the falling edge, hold it until the block takes it,
    // then optionally leave a random gap. Keeping start high across
    // back-to-back items avoids two assignments in one step.
    task automatic send_item(input op_t c, input logic [3:0] id, input logic f,
                             input logic [31:0] dly, input logic [31:0] t_now);
        int gap;
        op       <= c;
        task_id  <= id;
        is_fast  <= f;
        delay_ms <= dly;
        now      <= t_now;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        // Mostly no gap, often short gaps, rarely a long one.
        case ($urandom_range(0, 9))
            0, 1, 2:    gap = $urandom_range(1, 3);
            3:          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
            default:    gap = 0;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
    endtask

    // Hold the sender until every queued dispatch has come out, plus
    // margin for a command that produces nothing but keeps the block busy.
    task automatic drain_dispatches();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (4 * MAX_TASKS)
            @(negedge clk);
    endtask

    // One well-formed burst: arm and queue a handful of tasks, then tick.
    task automatic run_burst();
        int n;
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0, 1:    send_item(OP_TENQ, 4'($urandom_range(0, 15)),
                                   1'($urandom_range(0, 1)),
                                   $urandom_range(0, 40), clock_ms);
                2:       send_item(OP_ENQ, 4'($urandom_range(0, 15)),
                                   $urandom_range(0, 3) == 0, $urandom, clock_ms);
                3:       send_item(OP_DEQ, 4'($urandom_range(0, 15)),
                                   1'($urandom_range(0, 1)), $urandom, clock_ms);
                4:       send_item(OP_TENQ, 4'($urandom_range(0, 15)),
                                   1'($urandom_range(0, 1)), $urandom, $urandom);
                default: send_item(OP_ENQ, 4'($urandom_range(0, 15)), 1'b0, $urandom,
                                   clock_ms);
            endcase
        end
        clock_ms = clock_ms + $urandom_range(0, 30);
        send_item(OP_PROC, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom,
                  clock_ms);
    endtask

    initial
    begin
        cycle_count = 0;
        items_sent  = 0;
        clock_ms    = 32'd1000;
        rst_n    = 1'b0;
        start    = 1'b0;
        op       = OP_ENQ;
        task_id  = '0;
        is_fast  = 1'b0;
        delay_ms = '0;
        now      = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: fast dispatch, queueing, already-queued, dequeue of free,
        // equal deadlines keeping order, saturation, re-arm and expiry.
        send_item(OP_ENQ, 4'd0, 1'b1, 32'd0, 32'd0);
        send_item(OP_ENQ, 4'd15, 1'b0, 32'd0, 32'd0);
        send_item(OP_ENQ, 4'd15, 1'b1, 32'd0, 32'd0);
        send_item(OP_DEQ, 4'd7, 1'b0, 32'd0, 32'd0);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'd0);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'd0);
        send_item(OP_TENQ, 4'd3, 1'b1, 32'd10, 32'd100);
        send_item(OP_TENQ, 4'd5, 1'b0, 32'd10, 32'd100);
        send_item(OP_TENQ, 4'd1, 1'b0, 32'd5, 32'd100);
        send_item(OP_TENQ, 4'd9, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_TENQ, 4'd2, 1'b0, 32'd50, 32'd100);
        send_item(OP_TENQ, 4'd2, 1'b0, 32'd1, 32'd100);
        send_item(OP_ENQ, 4'd8, 1'b0, 32'd0, 32'd100);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'd110);
        send_item(OP_TENQ, 4'd6, 1'b0, 32'd20, 32'd0);
        send_item(OP_ENQ, 4'd6, 1'b1, 32'd0, 32'd0);
        send_item(OP_TENQ, 4'd4, 1'b0, 32'd0, 32'd0);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'd0);
        send_item(OP_ENQ, 4'd4, 1'b1, 32'd0, 32'd0);
        send_item(OP_TENQ, 4'd10, 1'b0, 32'd0, 32'd0);
        send_item(OP_DEQ, 4'd10, 1'b0, 32'd0, 32'd0);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
        drain_dispatches();

        // Fill all sixteen slots, then one tick dispatches the maximum.
        for (int i = 0; i < MAX_TASKS; i++)
            send_item(OP_ENQ, i[3:0], 1'b0, $urandom, 32'd0);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'd0);
        for (int i = 0; i < MAX_TASKS; i++)
            send_item(OP_TENQ, i[3:0], 1'b0, $urandom_range(0, 3), 32'd5);
        send_item(OP_PROC, 4'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
        drain_dispatches();

        // Random: mostly well-formed bursts around a rising clock, some noise.
        while (items_sent < 470)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)), $urandom, $urandom);
            else
                run_burst();
            if ($urandom_range(0, 40) == 0)
                drain_dispatches();
        end
        drain_dispatches();

        $display("Sent %0d commands and checked %0d dispatches, including full-queue ticks,",
                 items_sent, dispatch_seen);
        $display("deadline saturation, re-arming, fast dispatch and idle ticks.");
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- timer_and_run_queue_scheduler.f -----
rtl/core/trqs_pkg.sv
rtl/core/timer_and_run_queue_scheduler.sv
rtl/core/trqs_chk.sv
tb/trqs_checker.sv
tb/tb.sv
